// File: hdl/lwes_pkg.sv
package lwes_pkg;

    // Widths of the fixed payload and register fields.
    localparam int unsigned TARGET_W = 24;
    localparam int unsigned IDX_W    = 10;
    localparam int unsigned WVAL_W   = 16;
    localparam int unsigned BEST_W   = 11;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned APB_AW   = 3;

    // Default sizes of the storage.
    localparam int unsigned TABLE_DEPTH_DEF  = 1024;
    localparam int unsigned WINDOW_DEPTH_DEF = 1024;
    localparam int unsigned WEIGHT_BITS_DEF  = 16;

    // Operation codes carried on the op field.
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_PROCESS = 1'b1;

    // Register indexes on the configuration port.
    localparam logic REG_TARGET = 1'b0;

endpackage

// File: hdl/longest_window_with_exact_sum.sv
// Longest window with exact sum.
//
// Requests arrive on the s_ channel (valid/ready). A request with op = 0 writes
// weight_value into the weight table at entry_index. A request with op = 1
// looks up the weight at entry_index, pushes it into the window memory and
// then drops the oldest weights while the window sum exceeds target_sum. An
// op = 1 request with last set produces one result on the m_ channel: the
// longest window length that summed to target_sum, and the overflow flag.
// The window is then cleared for the next sequence.
//
// Steps: an op = 1 request passes through lookup, then shrink, which drops one
// oldest weight per step until the sum no longer exceeds target_sum, and then
// emit when it carries last. Every weight is dropped at most once. The drop rate
// is set by the single read port of the window memory, which returns one oldest
// weight per cycle. A result waits in the output register while m_ready is low;
// requests are still taken, and only a second last request waits for it.
// target_sum is written over the APB port at byte address 0.
// Reset (aresetn low, synchronous) empties the window and clears target_sum;
// the weight table keeps no defined contents until written.
module longest_window_with_exact_sum #(
    parameter int unsigned TABLE_DEPTH  = lwes_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned WINDOW_DEPTH = lwes_pkg::WINDOW_DEPTH_DEF,
    parameter int unsigned WEIGHT_BITS  = lwes_pkg::WEIGHT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Request channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [lwes_pkg::IDX_W-1:0]    s_entry_index,
    input  logic [lwes_pkg::WVAL_W-1:0]   s_weight_value,
    input  logic                          s_last,
    // Result channel.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lwes_pkg::BEST_W-1:0]   m_best_length,
    output logic                          m_overflow,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lwes_pkg::APB_AW-1:0]   paddr,
    input  logic [lwes_pkg::APB_DW-1:0]   pwdata,
    output logic [lwes_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int unsigned TA_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned PW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned WB    = WEIGHT_BITS;
    localparam int unsigned TOT_W = WB + CNT_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_SHRINK = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] best_reg, best_next;
    logic             overflow_reg, overflow_next;
    logic [lwes_pkg::TARGET_W-1:0] target_reg;
    logic             last_reg;
    logic             idx_ok_reg;
    logic             m_valid_reg, m_valid_next;
    logic [lwes_pkg::BEST_W-1:0] m_best_reg;
    logic             m_overflow_reg;

    logic [WB-1:0]    table_mem [TABLE_DEPTH];
    logic [WB-1:0]    table_rd_reg;
    logic [WB-1:0]    window_mem [WINDOW_DEPTH];
    logic [WB-1:0]    head_data_reg;

    logic             s_fire;
    logic             cfg_wr;
    logic [31:0]      idx_ext;
    logic [31:0]      wval_ext;
    logic [31:0]      best_ext;
    logic [TA_W-1:0]  table_addr;
    logic             idx_ok;
    logic [WB-1:0]    push_weight;
    logic             win_full;
    logic [PW-1:0]    head_inc;
    logic [PW-1:0]    tail_inc;
    logic             win_we;
    logic             pop_now;
    logic             emit_now;

    // Handshakes and decoded request fields.
    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign idx_ext    = 32'(s_entry_index);
    assign wval_ext   = 32'(s_weight_value);
    assign table_addr = idx_ext[TA_W-1:0];
    assign idx_ok     = idx_ext < 32'(TABLE_DEPTH);

    assign m_valid       = m_valid_reg;
    assign m_best_length = m_best_reg;
    assign m_overflow    = m_overflow_reg;

    // Configuration port: one register, always ready.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == lwes_pkg::REG_TARGET);
    assign prdata = (paddr[2] == lwes_pkg::REG_TARGET) ?
                    lwes_pkg::APB_DW'(target_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
        end else if (cfg_wr) begin
            target_reg <= pwdata[lwes_pkg::TARGET_W-1:0];
        end
    end

    // Weight table: written by op = 0 requests, read at every request address.
    always_ff @(posedge aclk) begin
        if (s_fire && s_op == lwes_pkg::OP_WRITE && idx_ok) begin
            table_mem[table_addr] <= wval_ext[WB-1:0];
        end
        table_rd_reg <= table_mem[table_addr];
    end

    // Window pointer arithmetic and the push of a looked-up weight.
    assign head_inc    = (head_reg == PW'(WINDOW_DEPTH - 1)) ? '0 : head_reg + PW'(1);
    assign tail_inc    = (tail_reg == PW'(WINDOW_DEPTH - 1)) ? '0 : tail_reg + PW'(1);
    assign push_weight = idx_ok_reg ? table_rd_reg : '0;
    assign win_full    = (count_reg == CNT_W'(WINDOW_DEPTH));
    assign win_we      = (state_reg == ST_LOOKUP);
    assign pop_now     = (64'(total_reg) > 64'(target_reg)) && (count_reg != '0);
    assign emit_now    = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign best_ext    = 32'(best_reg);

    // Window memory. The read port always fetches the entry at the next head,
    // so head_data_reg holds the oldest weight; a write to that entry in the
    // same cycle is forwarded.
    always_ff @(posedge aclk) begin
        if (win_we) begin
            window_mem[tail_reg] <= push_weight;
        end
        if (win_we && tail_reg == head_next) begin
            head_data_reg <= push_weight;
        end else begin
            head_data_reg <= window_mem[head_next];
        end
    end

    // Sequencer: lookup, push, shrink while over target, record, then emit on last.
    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        best_next     = best_reg;
        overflow_next = overflow_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_op == lwes_pkg::OP_PROCESS) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // A full window first drops its oldest weight.
                tail_next = tail_inc;
                if (win_full) begin
                    head_next     = head_inc;
                    total_next    = total_reg - TOT_W'(head_data_reg) + TOT_W'(push_weight);
                    overflow_next = 1'b1;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    total_next = total_reg + TOT_W'(push_weight);
                end
                state_next = ST_SHRINK;
            end
            ST_SHRINK: begin
                if (pop_now) begin
                    head_next  = head_inc;
                    count_next = count_reg - CNT_W'(1);
                    total_next = total_reg - TOT_W'(head_data_reg);
                end else begin
                    if (64'(total_reg) == 64'(target_reg) && count_reg > best_reg) begin
                        best_next = count_reg;
                    end
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (emit_now) begin
                    m_valid_next  = 1'b1;
                    head_next     = '0;
                    tail_next     = '0;
                    count_next    = '0;
                    total_next    = '0;
                    best_next     = '0;
                    overflow_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            total_reg    <= '0;
            best_reg     <= '0;
            overflow_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            best_reg     <= best_next;
            overflow_reg <= overflow_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Request attributes held while the request is worked on, and the result.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            last_reg   <= s_last;
            idx_ok_reg <= idx_ok;
        end
        if (emit_now) begin
            m_best_reg     <= best_ext[lwes_pkg::BEST_W-1:0];
            m_overflow_reg <= overflow_reg;
        end
    end

    // The window never holds more weights than its depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("window count beyond depth");

    // An empty window sums to zero.
    a_empty_total: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> total_reg == '0)
        else $error("empty window with nonzero total");

    // A sequence element always goes on to the table lookup.
    a_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_op == lwes_pkg::OP_PROCESS |=> state_reg == ST_LOOKUP)
        else $error("sequence element did not start a lookup");

    // Shrinking ends only once the window sum is within the target.
    a_shrink_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SHRINK && state_next != ST_SHRINK |->
            64'(total_reg) <= 64'(target_reg))
        else $error("shrink left the window above target");

    // A result appears only from the emit step.
    a_emit_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("result raised outside emit");

endmodule

// File: test/lwes_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and configuration channels of the longest window block.
// It keeps its own copy of the weight table, the window and target_sum, predicts the
// result of every op = 1 request that carries last, and compares each result
// with the oldest prediction.
module lwes_checker #(
    parameter int unsigned TABLE_DEPTH  = lwes_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned WINDOW_DEPTH = lwes_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_op,
    input  logic [lwes_pkg::IDX_W-1:0]     s_entry_index,
    input  logic [lwes_pkg::WVAL_W-1:0]    s_weight_value,
    input  logic                           s_last,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [lwes_pkg::BEST_W-1:0]    m_best_length,
    input  logic                           m_overflow,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [lwes_pkg::APB_AW-1:0]    paddr,
    input  logic [lwes_pkg::APB_DW-1:0]    pwdata,
    output int unsigned                    fail_count,
    output int unsigned                    results_owed
);

    localparam logic [lwes_pkg::APB_AW-1:0] TARGET_ADDR =
        lwes_pkg::APB_AW'(4 * lwes_pkg::REG_TARGET);
    localparam int unsigned PRINT_LIMIT = 50;

    typedef struct packed {
        logic [lwes_pkg::BEST_W-1:0] best_length;
        logic                        overflow;
    } window_result_t;

    // Shadow state of the block.
    logic [lwes_pkg::WVAL_W-1:0]   weight_shadow [0:TABLE_DEPTH-1];
    logic [lwes_pkg::WVAL_W-1:0]   window_weights [$];
    longint unsigned               window_sum    = 0;
    int unsigned                   longest_match = 0;
    logic                          overflow_hit  = 1'b0;
    logic [lwes_pkg::TARGET_W-1:0] target_shadow = '0;

    window_result_t      expected_results [$];
    int unsigned         mismatches = 0;

    always @(posedge aclk) begin : watch
        window_result_t              want;
        logic [lwes_pkg::WVAL_W-1:0] weight;

        if (aresetn) begin
            // Results are checked first, so a request taken at the same edge cannot
            // stand in for a result that was never predicted.
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= PRINT_LIMIT) begin
                        $display("%0t: result with none expected: best_length=%0d overflow=%0d",
                                 $time, m_best_length, m_overflow);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (m_best_length !== want.best_length) begin
                        mismatches++;
                        if (mismatches <= PRINT_LIMIT) begin
                            $display("%0t: best_length expected %0d, actual %0d",
                                     $time, want.best_length, m_best_length);
                        end
                    end
                    if (m_overflow !== want.overflow) begin
                        mismatches++;
                        if (mismatches <= PRINT_LIMIT) begin
                            $display("%0t: overflow expected %0d, actual %0d",
                                     $time, want.overflow, m_overflow);
                        end
                    end
                end
            end

            // A completed register write updates the target.
            if (psel && penable && pwrite && pready && paddr == TARGET_ADDR) begin
                target_shadow = pwdata[lwes_pkg::TARGET_W-1:0];
            end

            // Each accepted request either writes the table or advances the window.
            if (s_valid && s_ready) begin
                if (s_op == lwes_pkg::OP_WRITE) begin
                    if (32'(s_entry_index) < TABLE_DEPTH) begin
                        weight_shadow[s_entry_index] = s_weight_value;
                    end
                end else begin
                    // An index past the table reads as a zero weight.
                    if (32'(s_entry_index) < TABLE_DEPTH) begin
                        weight = weight_shadow[s_entry_index];
                    end else begin
                        weight = '0;
                    end
                    // A full window loses its oldest weight and marks the sequence.
                    if (window_weights.size() >= WINDOW_DEPTH) begin
                        window_sum -= window_weights.pop_front();
                        overflow_hit = 1'b1;
                    end
                    window_weights.insert(window_weights.size(), weight);
                    window_sum += weight;
                    while (window_sum > target_shadow && window_weights.size() > 0) begin
                        window_sum -= window_weights.pop_front();
                    end
                    if (window_sum == target_shadow && window_weights.size() > longest_match) begin
                        longest_match = window_weights.size();
                    end
                    // The end of a sequence reports and starts a fresh window.
                    if (s_last) begin
                        want.best_length = longest_match[lwes_pkg::BEST_W-1:0];
                        want.overflow    = overflow_hit;
                        expected_results.insert(expected_results.size(), want);
                        window_weights.delete();
                        window_sum    = 0;
                        longest_match = 0;
                        overflow_hit  = 1'b0;
                    end
                end
            end
        end
        fail_count   <= mismatches;
        results_owed <= expected_results.size();
    end

endmodule

// File: test/tb_longest_window_with_exact_sum.sv
`timescale 1ns / 1ps

module tb_longest_window_with_exact_sum;

    localparam logic [lwes_pkg::APB_AW-1:0]   TARGET_ADDR  =
        lwes_pkg::APB_AW'(4 * lwes_pkg::REG_TARGET);
    localparam logic [lwes_pkg::TARGET_W-1:0] TARGET_MAX   = '1;
    localparam int unsigned                   SMALL_POOL   = 64;
    localparam int unsigned                   RANDOM_ITEMS = 1300;
    localparam int unsigned                   PHASE_ITEMS  = 60;
    localparam int unsigned                   SETTLE       = 20;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_op;
    logic [lwes_pkg::IDX_W-1:0]    s_entry_index;
    logic [lwes_pkg::WVAL_W-1:0]   s_weight_value;
    logic                          s_last;
    logic                          m_valid;
    logic                          m_ready;
    logic [lwes_pkg::BEST_W-1:0]   m_best_length;
    logic                          m_overflow;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [lwes_pkg::APB_AW-1:0]   paddr;
    logic [lwes_pkg::APB_DW-1:0]   pwdata;
    logic [lwes_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    int unsigned         fail_count;
    int unsigned         results_owed;

    // Stimulus bookkeeping: table entries already written, and the request count.
    bit                  entry_written [0:lwes_pkg::TABLE_DEPTH_DEF-1];
    int unsigned         written_list [$];
    int unsigned         requests_sent = 0;
    bit                  steady = 1'b0;

    longest_window_with_exact_sum DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_entry_index  (s_entry_index),
        .s_weight_value (s_weight_value),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_best_length  (m_best_length),
        .m_overflow     (m_overflow),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    lwes_checker window_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_entry_index  (s_entry_index),
        .s_weight_value (s_weight_value),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_best_length  (m_best_length),
        .m_overflow     (m_overflow),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .fail_count     (fail_count),
        .results_owed   (results_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // Mostly short gaps, a few long ones, none while running steady.
    function automatic int unsigned idle_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 24);
    endfunction

    // The result side alternates ready stretches and stalls, and stays ready while running steady.
    initial begin
        forever begin
            m_ready <= 1'b1;
            if (steady) begin
                @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                m_ready <= 1'b0;
                repeat (1 + idle_gap()) @(posedge aclk);
            end
        end
    end

    // Offers one request and returns at the edge that accepts it.
    task automatic send_request(input logic op, input logic [lwes_pkg::IDX_W-1:0] index,
                                input logic [lwes_pkg::WVAL_W-1:0] weight,
                                input logic last_flag);
        int unsigned gap;
        gap = idle_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_entry_index  <= index;
        s_weight_value <= weight;
        s_last         <= last_flag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
    endtask

    task automatic load_entry(input int unsigned index,
                              input logic [lwes_pkg::WVAL_W-1:0] weight,
                              input logic last_flag);
        send_request(lwes_pkg::OP_WRITE, lwes_pkg::IDX_W'(index), weight, last_flag);
        if (!entry_written[index]) begin
            entry_written[index] = 1'b1;
            written_list.insert(written_list.size(), index);
        end
    endtask

    // A sequence element; the weight field is ignored here, so it is random.
    task automatic visit(input int unsigned index, input logic last_flag);
        send_request(lwes_pkg::OP_PROCESS, lwes_pkg::IDX_W'(index),
                     lwes_pkg::WVAL_W'($urandom), last_flag);
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Register write with setup and access cycles; upper data bits are don't-care.
    task automatic write_target(input logic [lwes_pkg::TARGET_W-1:0] value);
        logic [lwes_pkg::APB_DW-1:0] word;
        word                           = $urandom;
        word[lwes_pkg::TARGET_W-1:0]   = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TARGET_ADDR;
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Lookups favor the pool of small weights so that exact sums are common.
    function automatic int unsigned pick_index();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(0, SMALL_POOL - 1);
        end
        return written_list[$urandom_range(0, written_list.size() - 1)];
    endfunction

    // One phase: a target, then whole sequences with a little table noise mixed in.
    task automatic run_phase(input logic [lwes_pkg::TARGET_W-1:0] target,
                             input int unsigned budget);
        int unsigned stop_at;
        int unsigned length;
        int unsigned slot;
        stop_at = requests_sent + budget;
        drain();
        write_target(target);
        while (requests_sent < stop_at) begin
            length = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 60) : $urandom_range(1, 10);
            for (int unsigned n = 0; n < length; n++) begin
                if ($urandom_range(0, 99) < 8) begin
                    slot = $urandom_range(0, lwes_pkg::TABLE_DEPTH_DEF - 1);
                    load_entry(slot, (slot < SMALL_POOL) ?
                                     lwes_pkg::WVAL_W'($urandom_range(0, 15)) :
                                     lwes_pkg::WVAL_W'($urandom),
                               1'($urandom));
                end
                visit(pick_index(), n == length - 1);
            end
            // Now and then the sender holds off until the results catch up.
            if ($urandom_range(0, 99) < 5) begin
                drain();
            end
        end
    endtask

    function automatic logic [lwes_pkg::TARGET_W-1:0] pick_target();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            return '0;
        end
        if (roll == 1) begin
            return TARGET_MAX;
        end
        if (roll == 2) begin
            return lwes_pkg::TARGET_W'($urandom);
        end
        return lwes_pkg::TARGET_W'($urandom_range(1, 40));
    endfunction

    initial begin
        int unsigned phase;
        int unsigned zero_slot;
        int unsigned run_length;

        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_op           <= lwes_pkg::OP_WRITE;
        s_entry_index  <= '0;
        s_weight_value <= '0;
        s_last         <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: table extremes, last on a table write, zero and full-scale targets.
        load_entry(0, '0, 1'b1);
        load_entry(lwes_pkg::TABLE_DEPTH_DEF - 1, '1, 1'b0);
        load_entry(1, lwes_pkg::WVAL_W'(1), 1'b0);
        load_entry(2, lwes_pkg::WVAL_W'(2), 1'b0);
        drain();
        write_target('0);
        // A nonzero weight against a zero target leaves an empty window.
        visit(1, 1'b1);
        visit(0, 1'b0);
        visit(0, 1'b0);
        visit(1, 1'b0);
        visit(0, 1'b1);
        drain();
        write_target(lwes_pkg::TARGET_W'(3));
        visit(1, 1'b0);
        visit(2, 1'b0);
        visit(lwes_pkg::TABLE_DEPTH_DEF - 1, 1'b0);
        visit(2, 1'b0);
        visit(1, 1'b0);
        visit(0, 1'b1);
        drain();
        write_target(TARGET_MAX);
        visit(lwes_pkg::TABLE_DEPTH_DEF - 1, 1'b0);
        visit(lwes_pkg::TABLE_DEPTH_DEF - 1, 1'b0);
        visit(0, 1'b1);

        // Fill the pool of small weights and scatter full-range weights elsewhere.
        for (int unsigned slot = 0; slot < SMALL_POOL; slot++) begin
            load_entry(slot, lwes_pkg::WVAL_W'($urandom_range(0, 15)), 1'($urandom));
        end
        repeat (48) begin
            load_entry($urandom_range(SMALL_POOL, lwes_pkg::TABLE_DEPTH_DEF - 1),
                       lwes_pkg::WVAL_W'($urandom), 1'($urandom));
        end

        phase = 0;
        while (requests_sent < RANDOM_ITEMS / 5) begin
            steady = (phase == 2);
            run_phase(pick_target(), PHASE_ITEMS);
            phase++;
        end
        steady = 1'b0;

        // Window overflow: a zero target and a run of zero weights longer than the window.
        drain();
        write_target('0);
        zero_slot = $urandom_range(SMALL_POOL, lwes_pkg::TABLE_DEPTH_DEF - 1);
        load_entry(zero_slot, '0, 1'b0);
        run_length = lwes_pkg::WINDOW_DEPTH_DEF + $urandom_range(1, 16);
        for (int unsigned n = 0; n < run_length; n++) begin
            visit(zero_slot, n == run_length - 1);
        end

        while (requests_sent < RANDOM_ITEMS) begin
            steady = (phase == 6);
            run_phase(pick_target(), PHASE_ITEMS);
            phase++;
        end
        steady = 1'b0;

        drain();
        if (fail_count == 0 && results_owed == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
